>>> hw/rtl/rob_pkg.sv
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types and constants of the circular reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none
package rob_pkg;
    localparam int unsigned DepthDefault = 32;

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_ISSUE     = 3'd1,
        CMD_COMPLETE  = 3'd2,
        CMD_COMMIT    = 3'd3,
        CMD_FLUSH_ALL = 3'd4,
        CMD_FLUSH_AFT = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_HEAD_INV  = 3'd3,
        ST_HEAD_BUSY = 3'd4,
        ST_BAD_ENTRY = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        STG_ALLOC   = 2'd0,
        STG_ISSUED  = 2'd1,
        STG_DONE    = 2'd2,
        STG_RETIRED = 2'd3
    } stage_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_FLUSH,
        FSM_CLEAR,
        FSM_SCAN,
        FSM_OUT
    } fsm_t;
endpackage
`default_nettype wire

>>> hw/rtl/reorder_buffer_unit.sv
// ----------------------------------------------------------------------------
// reorder_buffer_unit
// Circular reorder buffer driven by one command beat at a time.
// ----------------------------------------------------------------------------
// a command runs an execute step, then flush all clears every payload slot
//   and flush after invalidates the slots after its entry, then a scan walks
//   all slots before the result beat; one command in flight, ready again in
//   the cycle after the result beat is taken
// the status scans walk the slots one per cycle through a single shared
//   index incrementer and compare
// reset: aresetn clears head, tail, occupancy and all valid bits at once
`default_nettype none
module reorder_buffer_unit #(
    parameter int unsigned DEPTH = rob_pkg::DepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[2:0], entry[7:3], pc[39:8], dest_reg[44:40], value[76:45],
    // exception[77], zero fill
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], entry_out[7:3], out_pc[39:8], out_value[71:40],
    // out_dest[76:72], out_exception[77], next_done[78], free_count[84:79],
    // dispatch_valid[85], dispatch_entry[90:86], exception_pending[91],
    // exception_entry[96:92], zero fill
    output logic [103:0]     m_tdata
);
    import rob_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // entry storage
    logic [DEPTH-1:0] vld_reg;
    stage_t           stg_reg [DEPTH];
    logic [31:0]      pc_reg  [DEPTH];
    logic [31:0]      val_reg [DEPTH];
    logic [4:0]       dst_reg [DEPTH];
    logic [DEPTH-1:0] flt_reg;

    logic [IW-1:0] head_reg, tail_reg;
    logic [CW-1:0] occ_reg;

    fsm_t fsm_reg, fsm_next;
    logic [77:0] in_reg;
    logic [IW-1:0] idx_reg;       // walking index
    logic [CW-1:0] cnt_reg;       // walk step counter
    status_t sts_reg;
    logic [4:0] eout_reg, odst_reg;
    logic [31:0] opc_reg, oval_reg;
    logic oexc_reg, more_reg;
    logic dv_reg, ev_reg;
    logic [4:0] de_reg, ee_reg;

    cmd_t cmd;
    logic [4:0] ent;
    logic ent_ok;
    logic [IW-1:0] ei, idx_inc, head_inc;
    assign cmd = cmd_t'(in_reg[2:0]);
    assign ent = in_reg[7:3];
    assign ent_ok = (32'(ent) < DEPTH);
    assign ei = IW'(ent);

    // shared wrap increment
    function automatic logic [IW-1:0] wrap(input logic [IW-1:0] i);
        wrap = (32'(i) == DEPTH - 1) ? '0 : i + IW'(1);
    endfunction
    assign idx_inc = wrap(idx_reg);
    assign head_inc = wrap(head_reg);

    assign s_tready = (fsm_reg == FSM_IDLE);
    assign m_tvalid = (fsm_reg == FSM_OUT);

    // result beat straight from the held result registers
    assign m_tdata = {7'd0, ee_reg, ev_reg, de_reg, dv_reg,
                      6'(DEPTH - 32'(occ_reg)), more_reg, oexc_reg, odst_reg,
                      oval_reg, opc_reg, eout_reg, sts_reg};

    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            FSM_IDLE: if (s_tvalid) fsm_next = FSM_EXEC;
            FSM_EXEC: begin
                if (cmd == CMD_FLUSH_ALL) fsm_next = FSM_CLEAR;
                else if (cmd == CMD_FLUSH_AFT && ent_ok) fsm_next = FSM_FLUSH;
                else fsm_next = FSM_SCAN;
            end
            FSM_FLUSH: if (idx_reg == tail_reg || !vld_reg[idx_reg] ||
                           32'(cnt_reg) == DEPTH) fsm_next = FSM_SCAN;
            FSM_CLEAR: if (32'(cnt_reg) == DEPTH - 1) fsm_next = FSM_SCAN;
            FSM_SCAN: if (32'(cnt_reg) == DEPTH - 1) fsm_next = FSM_OUT;
            FSM_OUT: if (m_tready) fsm_next = FSM_IDLE;
            default: fsm_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) fsm_reg <= FSM_IDLE;
        else fsm_reg <= fsm_next;
    end

    // datapath and sequencer actions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg <= '0;
        end else begin
            case (fsm_reg)
                // take the beat and preset the result fields
                FSM_IDLE: begin
                    if (s_tvalid) begin
                        in_reg <= s_tdata[77:0];
                        sts_reg <= ST_OK; eout_reg <= '0; opc_reg <= '0;
                        oval_reg <= '0; odst_reg <= '0; oexc_reg <= 1'b0;
                        more_reg <= 1'b0; dv_reg <= 1'b0; de_reg <= '0;
                        ev_reg <= 1'b0; ee_reg <= '0; cnt_reg <= '0;
                        idx_reg <= head_reg;
                    end
                end
                FSM_EXEC: begin
                    case (cmd)
                        CMD_ALLOC: begin
                            if (32'(occ_reg) >= DEPTH) sts_reg <= ST_FULL;
                            else begin
                                vld_reg[tail_reg] <= 1'b1;
                                stg_reg[tail_reg] <= STG_ALLOC;
                                pc_reg[tail_reg] <= in_reg[39:8];
                                val_reg[tail_reg] <= '0;
                                dst_reg[tail_reg] <= in_reg[44:40];
                                flt_reg[tail_reg] <= 1'b0;
                                tail_reg <= wrap(tail_reg);
                                occ_reg <= occ_reg + CW'(1);
                                eout_reg <= 5'(tail_reg);
                            end
                        end
                        CMD_ISSUE: begin
                            if (!ent_ok || !vld_reg[ei] || stg_reg[ei] != STG_ALLOC)
                                sts_reg <= ST_BAD_ENTRY;
                            else stg_reg[ei] <= STG_ISSUED;
                        end
                        CMD_COMPLETE: begin
                            if (!ent_ok || !vld_reg[ei]) sts_reg <= ST_BAD_ENTRY;
                            else begin
                                val_reg[ei] <= in_reg[76:45];
                                flt_reg[ei] <= in_reg[77];
                                stg_reg[ei] <= STG_DONE;
                            end
                        end
                        CMD_COMMIT: begin
                            if (occ_reg == '0) sts_reg <= ST_EMPTY;
                            else if (!vld_reg[head_reg]) sts_reg <= ST_HEAD_INV;
                            else if (stg_reg[head_reg] != STG_DONE)
                                sts_reg <= ST_HEAD_BUSY;
                            else begin
                                eout_reg <= 5'(head_reg);
                                opc_reg <= pc_reg[head_reg];
                                oval_reg <= val_reg[head_reg];
                                odst_reg <= dst_reg[head_reg];
                                oexc_reg <= flt_reg[head_reg];
                                if (!flt_reg[head_reg]) stg_reg[head_reg] <= STG_RETIRED;
                                vld_reg[head_reg] <= 1'b0;
                                head_reg <= head_inc;
                                idx_reg <= head_inc;
                                occ_reg <= occ_reg - CW'(1);
                                more_reg <= (occ_reg != CW'(1)) &&
                                    (head_inc != head_reg) && vld_reg[head_inc] &&
                                    stg_reg[head_inc] == STG_DONE;
                            end
                        end
                        CMD_FLUSH_ALL: begin
                            vld_reg <= '0; head_reg <= '0; tail_reg <= '0;
                            occ_reg <= '0; idx_reg <= '0;
                        end
                        CMD_FLUSH_AFT: begin
                            if (!ent_ok) sts_reg <= ST_BAD_ENTRY;
                            else idx_reg <= wrap(ei);
                        end
                        default: ;
                    endcase
                end
                // walk from the slot after the entry, invalidating
                FSM_FLUSH: begin
                    if (idx_reg == tail_reg || !vld_reg[idx_reg] ||
                        32'(cnt_reg) == DEPTH) begin
                        tail_reg <= wrap(ei);
                        idx_reg <= head_reg;
                        cnt_reg <= '0;
                    end else begin
                        vld_reg[idx_reg] <= 1'b0;
                        if (occ_reg != '0) occ_reg <= occ_reg - CW'(1);
                        idx_reg <= idx_inc;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                // one payload slot per cycle back to its reset value
                FSM_CLEAR: begin
                    stg_reg[IW'(cnt_reg)] <= STG_ALLOC;
                    pc_reg[IW'(cnt_reg)] <= '0;
                    val_reg[IW'(cnt_reg)] <= '0;
                    dst_reg[IW'(cnt_reg)] <= '0;
                    flt_reg[IW'(cnt_reg)] <= 1'b0;
                    cnt_reg <= (32'(cnt_reg) == DEPTH - 1) ? '0 : cnt_reg + CW'(1);
                end
                // oldest-first scan for dispatch and exception
                FSM_SCAN: begin
                    if (!dv_reg && vld_reg[idx_reg] && stg_reg[idx_reg] == STG_ALLOC) begin
                        dv_reg <= 1'b1; de_reg <= 5'(idx_reg);
                    end
                    if (!ev_reg && cnt_reg < occ_reg && vld_reg[idx_reg] &&
                        flt_reg[idx_reg]) begin
                        ev_reg <= 1'b1; ee_reg <= 5'(idx_reg);
                    end
                    idx_reg <= idx_inc;
                    cnt_reg <= cnt_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/rob_checker.sv
// ----------------------------------------------------------------------------
// rob_checker
// Port-level checks of the reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rob_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata
);
    // one command in flight: never ready while a result is shown
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready while result pending");
    // an accepted beat stops readiness next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
    // status code stays in range
    a_sts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd5) else $error("bad status");
    // held result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
endmodule

bind reorder_buffer_unit rob_checker u_rob_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
